// ===== design/i2t_pkg.sv =====
// Shared types, codes and character constants of the integer-to-text formatter.
`default_nettype none
package i2t_pkg;

  // Radix selector codes; code three is served as hexadecimal.
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Fixed widths of the request fields and the output character.
  localparam int MAG_W    = 32;
  localparam int IN_BITS  = 52;
  localparam int IN_BYTES = 7;
  localparam int OUT_W    = 8;

  // ASCII characters used by the formatter.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  // One request as it sits in the low bits of the input data, last field lowest.
  typedef struct packed {
    logic              prefix_form;
    logic              blank_sign;
    logic              minus_sign;
    logic              caps;
    logic              pad_zeros;
    logic              align_left;
    logic [5:0]        min_digits;
    logic [5:0]        field_width;
    logic [1:0]        radix_select;
    logic [MAG_W-1:0]  magnitude;
  } i2t_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_SIZE,
    ST_EMIT
  } i2t_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic convert;
    logic count;
    logic size;
    logic emit;
  } i2t_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic convert_done;
    logic out_free;
    logic last_char;
  } i2t_status_t;

  // ASCII code of one digit value.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/i2t_ctrl.sv =====
// Controller state machine of the integer-to-text formatter.
`default_nettype none
module i2t_ctrl
  import i2t_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  output      i2t_cmd_t    cmd,
  input  wire i2t_status_t status
);

  i2t_state_t state;
  i2t_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status.convert_done) state_next = ST_COUNT;
      end
      ST_COUNT: state_next = ST_SIZE;
      ST_SIZE:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free && status.last_char) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: cmd.convert = !status.convert_done;
      ST_COUNT:   cmd.count   = 1'b1;
      ST_SIZE:    cmd.size    = 1'b1;
      ST_EMIT:    cmd.emit    = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/i2t_datapath.sv =====
// Datapath of the integer-to-text formatter: digit store, sizing and character output.
`default_nettype none
module i2t_datapath
  import i2t_pkg::*;
#(
  parameter int VALUE_BITS    = 32,
  parameter int MAX_WIDTH     = 48,
  parameter int MAX_PRECISION = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire i2t_req_t    req,
  input  wire i2t_cmd_t    cmd,
  output      i2t_status_t status,
  input  wire logic        out_ready,
  output      logic        out_valid,
  output      logic [7:0]  out_char,
  output      logic        out_last
);

  localparam int DEPTH = (VALUE_BITS + 2) / 3;
  localparam int SW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH + MAX_PRECISION + DEPTH + 4);
  localparam int BW    = $clog2(VALUE_BITS + 1);
  localparam int EXT_W = (VALUE_BITS > MAG_W) ? VALUE_BITS : MAG_W;
  localparam int PADW  = 4 * DEPTH;

  logic [VALUE_BITS-1:0] val;
  logic [BW-1:0]         step_cnt;
  logic [1:0]            rsel;
  logic                  caps, minus, blank, pfx, left, zpad;
  logic [CW-1:0]         width_sat, prec_sat;
  logic [3:0]            store [DEPTH];
  logic [CW-1:0]         digit_total;
  logic [CW-1:0]         b_lead, b_sign, b_pfx, b_zero, b_dig, total;
  logic [CW-1:0]         pos;

  logic [EXT_W-1:0]      mag_ext;
  logic [PADW-1:0]       mag_pad;
  logic [3:0]            adj [DEPTH];
  logic [3:0]            dabbled [DEPTH];
  logic [CW-1:0]         found_total;
  logic [CW-1:0]         w_in, p_in;

  assign mag_ext = EXT_W'(req.magnitude);
  assign mag_pad = PADW'(mag_ext[VALUE_BITS-1:0]);
  assign w_in    = CW'(req.field_width);
  assign p_in    = CW'(req.min_digits);

  // One shift-and-adjust step of binary to BCD conversion.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      adj[i] = (store[i] >= 4'd5) ? store[i] + 4'd3 : store[i];
    end
    dabbled[0] = {adj[0][2:0], val[VALUE_BITS-1]};
    for (int i = 1; i < DEPTH; i++) begin
      dabbled[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // Significant digit count: highest nonzero digit, at least one.
  always_comb begin
    found_total = CW'(1);
    for (int i = 0; i < DEPTH; i++) begin
      if (store[i] != 4'd0) found_total = CW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsel      <= req.radix_select;
      caps      <= req.caps;
      minus     <= req.minus_sign;
      blank     <= req.blank_sign;
      pfx       <= req.prefix_form;
      left      <= req.align_left;
      zpad      <= req.pad_zeros;
      width_sat <= (w_in > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_in;
      prec_sat  <= (p_in > CW'(MAX_PRECISION)) ? CW'(MAX_PRECISION) : p_in;
      val       <= mag_ext[VALUE_BITS-1:0];
      for (int i = 0; i < DEPTH; i++) begin
        case (req.radix_select)
          RADIX_DEC: store[i] <= 4'd0;
          RADIX_OCT: store[i] <= {1'b0, mag_pad[3*i +: 3]};
          default:   store[i] <= mag_pad[4*i +: 4];
        endcase
      end
    end else if (cmd.convert) begin
      val <= {val[VALUE_BITS-2:0], 1'b0};
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= dabbled[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= (req.radix_select == RADIX_DEC) ? BW'(VALUE_BITS) : '0;
    end else if (cmd.convert) begin
      step_cnt <= step_cnt - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count) begin
      digit_total <= found_total;
    end
  end

  // Segment boundaries of the text, as running character positions.
  logic [CW-1:0] ndig, sign_len, pfx_len, used, pad, lead, zfill;

  always_comb begin
    ndig     = (digit_total > prec_sat) ? digit_total : prec_sat;
    sign_len = CW'(minus | blank);
    if (!pfx || rsel == RADIX_DEC) begin
      pfx_len = '0;
    end else if (rsel == RADIX_OCT) begin
      pfx_len = CW'(1);
    end else begin
      pfx_len = CW'(2);
    end
    used  = ndig + sign_len + pfx_len;
    pad   = (width_sat > used) ? width_sat - used : '0;
    lead  = (!left && !zpad) ? pad : '0;
    zfill = (!left && zpad) ? pad : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      b_lead <= lead;
      b_sign <= lead + sign_len;
      b_pfx  <= lead + sign_len + pfx_len;
      b_zero <= lead + sign_len + pfx_len + zfill;
      b_dig  <= lead + sign_len + pfx_len + zfill + ndig;
      if (used > CW'(MAX_WIDTH)) begin
        total <= CW'(MAX_WIDTH);
      end else begin
        total <= (width_sat > used) ? width_sat : used;
      end
      pos <= '0;
    end else if (cmd.emit) begin
      pos <= pos + CW'(1);
    end
  end

  // Character at the current position.
  logic [CW-1:0] didx;
  logic [3:0]    dval;
  logic [7:0]    ch;

  always_comb begin
    didx = b_dig - CW'(1) - pos;
    dval = (didx < digit_total) ? store[didx[SW-1:0]] : 4'd0;
    if (pos < b_lead) begin
      ch = CH_SPACE;
    end else if (pos < b_sign) begin
      ch = minus ? CH_MINUS : CH_SPACE;
    end else if (pos < b_pfx) begin
      if (pos == b_sign) begin
        ch = CH_ZERO;
      end else begin
        ch = caps ? CH_X_UP : CH_X_LO;
      end
    end else if (pos < b_zero) begin
      ch = CH_ZERO;
    end else if (pos < b_dig) begin
      ch = digit_char(dval, caps);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= ch;
      out_last <= (pos == total - CW'(1));
    end
  end

  assign status.convert_done = (step_cnt == '0);
  assign status.out_free     = !out_valid || out_ready;
  assign status.last_char    = (pos == total - CW'(1));

`ifndef NO_ASSERTIONS
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("character issued while the output register is still full");

  a_digit_count_range: assert property (@(posedge clk) disable iff (rst)
    cmd.size |-> (digit_total != '0 && digit_total <= CW'(DEPTH)))
    else $error("digit count outside the store depth");

  a_position_in_text: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (pos < total))
    else $error("character position ran past the end of the text");
`endif

endmodule
`default_nettype wire

// ===== design/integer_to_text_formatter_core.sv =====
// Top level of the integer-to-text formatter: stream ports, controller and datapath.
//
// Usage: one request on the slave stream carries an unsigned magnitude and its format
// flags; the block answers with the formatted text on the master stream, one ASCII
// character per beat, with tlast on the final character of that number. The text is
// never longer than MAX_WIDTH characters and never shorter than one.
// Requests are taken one at a time: s_tready is high only while the block is idle.
// After a request is taken, decimal conversion runs a binary-to-BCD shift loop over all
// VALUE_BITS bits; octal and hexadecimal digits are sliced off in the load cycle.
// The COUNT and SIZE states then count the digits and lay out the text. After that one
// character leaves per cycle while the receiver keeps up; a low m_tready stalls it.
// The next request is taken as soon as the last character sits in the output register.
// The output register holds its character while m_tready is low and the block waits.
// Reset (rst, synchronous, active high) empties the output register and returns the
// controller to idle; no clearing pass is needed.
`default_nettype none
module integer_to_text_formatter_core
  import i2t_pkg::*;
#(
  parameter int VALUE_BITS    = 32,
  parameter int MAX_WIDTH     = 48,
  parameter int MAX_PRECISION = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  // magnitude[31:0], radix_select[33:32], field_width[39:34], min_digits[45:40],
  // align_left[46], pad_zeros[47], caps[48], minus_sign[49], blank_sign[50],
  // prefix_form[51], zero fill[55:52]
  input  wire logic [8*IN_BYTES-1:0] s_tdata,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  // text_char[7:0]
  output      logic [OUT_W-1:0]     m_tdata,
  // final_char
  output      logic                 m_tlast
);

  i2t_req_t    req;
  i2t_cmd_t    cmd;
  i2t_status_t status;

  // The request fields sit in the low bits of tdata; the top fill bits [55:52] are ignored.
  assign req = i2t_req_t'(s_tdata[IN_BITS-1:0]);

  i2t_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  i2t_datapath #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire
